[hdl/rdf_pkg.sv]
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared constants, types and register codes for the radix digit formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

   localparam int VALUE_BITS  = 64;
   localparam int MAX_RADIX   = 16;
   localparam int DIGIT_W     = $clog2(MAX_RADIX);
   localparam int RADIX_W     = $clog2(MAX_RADIX + 1);
   localparam int SUM_W       = DIGIT_W + 1;
   localparam int CNT_W       = $clog2(VALUE_BITS);
   localparam int CHAR_W      = 8;
   localparam int CSR_RADIX_W = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int TABLE_W     = 2 * CSR_DATA_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_HIGH = 2'd2;

   localparam logic [CSR_RADIX_W-1:0] RADIX_RESET      = 5'd10;
   localparam logic [CSR_DATA_W-1:0]  CHARS_LOW_RESET  = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0]  CHARS_HIGH_RESET = 64'h6665646362613938;

   localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic emit;
      logic last_slot;
   } dp_cmd_type;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic [TABLE_W-1:0] chars;
   } cfg_type;

endpackage

[hdl/rdf_csr.sv]
// ----------------------------------------------------------------------------
// rdf_csr
// Configuration registers: radix and the sixteen-entry digit character table.
// ----------------------------------------------------------------------------
module rdf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rdf_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output rdf_pkg::cfg_type                  cfg
);

   logic [rdf_pkg::CSR_RADIX_W-1:0] radix_ff;
   logic [rdf_pkg::CSR_DATA_W-1:0]  chars_low_ff;
   logic [rdf_pkg::CSR_DATA_W-1:0]  chars_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= rdf_pkg::RADIX_RESET;
         chars_low_ff  <= rdf_pkg::CHARS_LOW_RESET;
         chars_high_ff <= rdf_pkg::CHARS_HIGH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rdf_pkg::CSR_RADIX: begin
               radix_ff <= csr_write_data[rdf_pkg::CSR_RADIX_W-1:0];
            end
            rdf_pkg::CSR_CHARS_LOW: begin
               chars_low_ff <= csr_write_data;
            end
            rdf_pkg::CSR_CHARS_HIGH: begin
               chars_high_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Out-of-range radix values are clamped to the supported span.
   always_comb begin
      if (radix_ff < rdf_pkg::CSR_RADIX_W'(2)) begin
         cfg.radix = rdf_pkg::RADIX_W'(2);
      end else if (radix_ff > rdf_pkg::CSR_RADIX_W'(rdf_pkg::MAX_RADIX)) begin
         cfg.radix = rdf_pkg::RADIX_W'(rdf_pkg::MAX_RADIX);
      end else begin
         cfg.radix = rdf_pkg::RADIX_W'(radix_ff);
      end
      cfg.chars = {chars_high_ff, chars_low_ff};
   end

endmodule

[hdl/rdf_ctrl.sv]
// ----------------------------------------------------------------------------
// rdf_ctrl
// Sequencer: one conversion pass over the value bits, then one pass over the
// digit slots that sends the digits out.
// ----------------------------------------------------------------------------
module rdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output rdf_pkg::dp_cmd_type cmd
);

   localparam logic [rdf_pkg::CNT_W-1:0] CNT_LAST = rdf_pkg::CNT_W'(rdf_pkg::VALUE_BITS - 1);

   rdf_pkg::state_type          state_ff, state_in;
   logic [rdf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdf_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd.load      = 1'b0;
      cmd.convert   = 1'b0;
      cmd.emit      = 1'b0;
      cmd.last_slot = 1'b0;
      busy          = 1'b1;
      unique case (state_ff)
         rdf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = rdf_pkg::ST_CONVERT;
            end
         end
         rdf_pkg::ST_CONVERT: begin
            cmd.convert = 1'b1;
            cnt_in      = cnt_ff + rdf_pkg::CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = rdf_pkg::ST_EMIT;
            end
         end
         rdf_pkg::ST_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.last_slot = (cnt_ff == CNT_LAST);
            cnt_in        = cnt_ff + rdf_pkg::CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = rdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdf_pkg::ST_IDLE;
         end
      endcase
   end

   a_start_begins_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdf_pkg::ST_IDLE && start) |=>
         (state_ff == rdf_pkg::ST_CONVERT && cnt_ff == '0))
      else $error("start did not begin a conversion pass");

   a_emit_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdf_pkg::ST_EMIT && cnt_ff == CNT_LAST) |=>
         (state_ff == rdf_pkg::ST_IDLE))
      else $error("emit pass did not return to idle");

endmodule

[hdl/rdf_dpath.sv]
// ----------------------------------------------------------------------------
// rdf_dpath
// Bit-serial radix conversion into a row of digit cells, then a shift of the
// digit row toward the top that sends out one character per slot after the leading zeros.
// ----------------------------------------------------------------------------
module rdf_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  rdf_pkg::dp_cmd_type               cmd,
   input  rdf_pkg::cfg_type                  cfg,
   input  logic [rdf_pkg::VALUE_BITS-1:0]    req_value,
   output logic                              rsp_strobe,
   output logic [rdf_pkg::CHAR_W-1:0]        rsp_character,
   output logic                              rsp_last
);

   localparam int VB = rdf_pkg::VALUE_BITS;

   logic [VB-1:0]                 value_ff, value_in;
   logic [rdf_pkg::DIGIT_W-1:0]   digit_ff [VB];
   logic [rdf_pkg::DIGIT_W-1:0]   digit_in [VB];
   logic [rdf_pkg::DIGIT_W-1:0]   digit_conv [VB];
   logic                          started_ff, started_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [rdf_pkg::CHAR_W-1:0]    rsp_character_ff, rsp_character_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [rdf_pkg::SUM_W-1:0]     radix_ext;
   logic [VB-1:0]                 gen, prop;
   logic [VB:0]                   carry_sum, carry;
   logic [rdf_pkg::SUM_W-1:0]     step [VB];
   logic [rdf_pkg::DIGIT_W-1:0]   top;
   logic                          top_nz;

   assign radix_ext = rdf_pkg::SUM_W'(cfg.radix);

   // Each cell computes 2*d + carry_in mod radix. The carry chain is formed
   // by an adder: generate when 2*d alone reaches the radix, propagate when
   // 2*d + 1 does.
   always_comb begin
      for (int i = 0; i < VB; i++) begin
         gen[i]  = ({digit_ff[i], 1'b0} >= radix_ext);
         prop[i] = ({digit_ff[i], 1'b1} >= radix_ext);
      end
      carry_sum = {1'b0, gen} + {1'b0, prop} + (VB + 1)'(value_ff[VB-1]);
      carry     = carry_sum ^ {1'b0, gen} ^ {1'b0, prop};
      for (int i = 0; i < VB; i++) begin
         step[i]       = {digit_ff[i], carry[i]} - (carry[i+1] ? radix_ext : '0);
         digit_conv[i] = step[i][rdf_pkg::DIGIT_W-1:0];
      end
   end

   assign top    = digit_ff[VB-1];
   assign top_nz = (top != '0);

   always_comb begin
      value_in   = value_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      priority if (cmd.load) begin
         value_in   = req_value;
         started_in = 1'b0;
         for (int i = 0; i < VB; i++) begin
            digit_in[i] = '0;
         end
      end else if (cmd.convert) begin
         value_in = {value_ff[VB-2:0], 1'b0};
         digit_in = digit_conv;
      end else if (cmd.emit) begin
         started_in  = started_ff | top_nz;
         digit_in[0] = '0;
         for (int i = 1; i < VB; i++) begin
            digit_in[i] = digit_ff[i-1];
         end
      end else begin
      end
   end

   // Leading zero slots are skipped; an all-zero number reaches the last slot
   // without a digit having been sent and prints as a plain zero.
   always_comb begin
      rsp_strobe_in = cmd.emit & (started_ff | top_nz | cmd.last_slot);
      rsp_last_in   = cmd.last_slot;
      if (!started_ff && !top_nz) begin
         rsp_character_in = rdf_pkg::ZERO_CHAR;
      end else begin
         rsp_character_in = cfg.chars[{top, 3'b000} +: rdf_pkg::CHAR_W];
      end
   end

   always_ff @(posedge clock) begin
      value_ff         <= value_in;
      digit_ff         <= digit_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
      if (reset) begin
         started_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         started_ff    <= started_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   a_last_slot_sends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last_slot) |=> (rsp_strobe_ff && rsp_last_ff))
      else $error("final slot did not send a last word");

   a_words_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_last_ff) |=> rsp_strobe_ff)
      else $error("gap inside the words of one number");

endmodule

[hdl/radix_digit_formatter.sv]
// ----------------------------------------------------------------------------
// radix_digit_formatter
// Writes a 64-bit unsigned value as text in a radix of 2 to 16, one character
// word per cycle, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   A value is taken on req_value at a clock edge where start is high and busy
//   is low. busy then stays high through a pass that shifts the value in one
//   bit per cycle through a row of 64 digit cells, then a pass over the digit
//   slots that skips leading zeros and sends one character per cycle. The
//   next value is taken only once busy is low again in the idle state.
//   Each character appears on rsp_character for one cycle with rsp_strobe
//   high, in the cycle after its slot; rsp_last marks the final character.
//   A zero value sends one word, the character '0'. The receiver takes every
//   word; it cannot stall the block.
//   Registers are written through csr_write_enable, csr_index and
//   csr_write_data: index 0 radix, 1 and 2 the digit character table. The
//   user must write them only while busy is low; the block itself does not
//   enforce this. Reset returns the registers to radix 10 with the table
//   "0123456789abcdef" and leaves the block idle.
// ----------------------------------------------------------------------------
module radix_digit_formatter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rdf_pkg::VALUE_BITS-1:0]    req_value,
   output logic                              rsp_strobe,
   output logic [rdf_pkg::CHAR_W-1:0]        rsp_character,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [rdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rdf_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   rdf_pkg::dp_cmd_type cmd;
   rdf_pkg::cfg_type    cfg;

   rdf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rdf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   rdf_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

[tb/radix_digit_formatter_tb.sv]
// ----------------------------------------------------------------------------
// radix_digit_formatter_tb
// Self-checking bench for the radix digit formatter. A driver sends numbers
// and register writes from a queue that the stimulus block fills. A monitor
// predicts the character words of every accepted number from its own copy of
// the registers and checks each word the block sends against the oldest
// prediction.
// ----------------------------------------------------------------------------
module radix_digit_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rdf_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES   = 140;

   typedef struct packed {
      logic [rdf_pkg::CHAR_W-1:0] character;
      logic                       is_last;
   } char_word_type;

   typedef enum {
      ACT_NUMBER,
      ACT_CSR,
      ACT_DRAIN
   } act_kind_type;

   typedef struct {
      act_kind_type                      kind;
      logic [rdf_pkg::CSR_DATA_W-1:0]    data;
      logic [rdf_pkg::CSR_INDEX_W-1:0]   index;
      int unsigned                       gap;
   } stim_act_type;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               start            = 1'b0;
   logic                               busy;
   logic [rdf_pkg::VALUE_BITS-1:0]     req_value        = '0;
   logic                               rsp_strobe;
   logic [rdf_pkg::CHAR_W-1:0]         rsp_character;
   logic                               rsp_last;
   logic                               csr_write_enable = 1'b0;
   logic [rdf_pkg::CSR_INDEX_W-1:0]    csr_index        = '0;
   logic [rdf_pkg::CSR_DATA_W-1:0]     csr_write_data   = '0;

   logic                               req_taken        = 1'b0;
   logic                               stimulus_done    = 1'b0;
   int unsigned                        mismatch_count   = 0;

   stim_act_type                       stim_queue[$];
   char_word_type                      expected_chars[$];

   // Bench copy of the configuration registers.
   logic [rdf_pkg::CSR_RADIX_W-1:0]    model_radix;
   logic [rdf_pkg::CSR_DATA_W-1:0]     model_chars_low;
   logic [rdf_pkg::CSR_DATA_W-1:0]     model_chars_high;

   // Driver progress through the current queue entry.
   stim_act_type                       current_act;
   bit                                 act_open         = 1'b0;
   int unsigned                        hold_count       = 0;

   radix_digit_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Splits a number into digits of the effective radix and queues one
   // character word per digit, most significant first.
   function automatic void predict_digits(input logic [rdf_pkg::VALUE_BITS-1:0] number);
      logic [63:0]                 rest;
      logic [63:0]                 base;
      logic [3:0]                  digits[64];
      logic [rdf_pkg::TABLE_W-1:0] charset;
      int                          count;
      char_word_type               w;
      rest    = number;
      charset = {model_chars_high, model_chars_low};
      if (model_radix < 2) begin
         base = 64'(2);
      end else if (model_radix > rdf_pkg::MAX_RADIX) begin
         base = 64'(rdf_pkg::MAX_RADIX);
      end else begin
         base = 64'(model_radix);
      end
      if (rest == 0) begin
         w.character = rdf_pkg::ZERO_CHAR;
         w.is_last   = 1'b1;
         expected_chars.push_back(w);
         return;
      end
      count = 0;
      while (rest != 0) begin
         digits[count] = 4'(rest % base);
         rest = rest / base;
         count++;
      end
      for (int k = count - 1; k >= 0; k--) begin
         w.character = charset[int'(digits[k]) * 8 +: 8];
         w.is_last   = (k == 0);
         expected_chars.push_back(w);
      end
   endfunction

   task automatic queue_number(input logic [rdf_pkg::VALUE_BITS-1:0] number,
                               input int unsigned gap);
      stim_act_type a;
      a.kind  = ACT_NUMBER;
      a.data  = number;
      a.index = rdf_pkg::CSR_RADIX;
      a.gap   = gap;
      stim_queue.push_back(a);
   endtask

   task automatic queue_csr(input logic [rdf_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rdf_pkg::CSR_DATA_W-1:0] data);
      stim_act_type a;
      a.kind  = ACT_CSR;
      a.data  = data;
      a.index = index;
      a.gap   = 0;
      stim_queue.push_back(a);
   endtask

   task automatic queue_drain();
      stim_act_type a;
      a.kind  = ACT_DRAIN;
      a.data  = '0;
      a.index = rdf_pkg::CSR_RADIX;
      a.gap   = 0;
      stim_queue.push_back(a);
   endtask

   always @(negedge clock) begin : drive_requests
      logic                            next_start;
      logic [rdf_pkg::VALUE_BITS-1:0]  next_value;
      logic                            next_we;
      logic [rdf_pkg::CSR_INDEX_W-1:0] next_index;
      logic [rdf_pkg::CSR_DATA_W-1:0]  next_data;
      logic                            next_done;
      next_start = start;
      next_value = req_value;
      next_we    = 1'b0;
      next_index = csr_index;
      next_data  = csr_write_data;
      next_done  = 1'b0;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (start && req_taken) begin
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (!act_open && stim_queue.size() != 0) begin
               current_act = stim_queue.pop_front();
               act_open    = 1'b1;
               hold_count  = (current_act.kind == ACT_NUMBER) ? current_act.gap
                                                              : SETTLE_CYCLES;
            end
            if (act_open) begin
               case (current_act.kind)
                  ACT_NUMBER: begin
                     if (hold_count != 0) begin
                        hold_count--;
                     end else begin
                        next_start = 1'b1;
                        next_value = current_act.data;
                        act_open   = 1'b0;
                     end
                  end
                  ACT_CSR: begin
                     // Registers change only once the block is idle and every
                     // word of the previous number has come out.
                     if (busy || expected_chars.size() != 0) begin
                        hold_count = SETTLE_CYCLES;
                     end else if (hold_count != 0) begin
                        hold_count--;
                     end else begin
                        next_we    = 1'b1;
                        next_index = current_act.index;
                        next_data  = current_act.data;
                        act_open   = 1'b0;
                     end
                  end
                  default: begin
                     if (!busy && expected_chars.size() == 0) begin
                        act_open = 1'b0;
                     end
                  end
               endcase
            end else begin
               next_done = 1'b1;
            end
         end
      end
      start            <= next_start;
      req_value        <= next_value;
      csr_write_enable <= next_we;
      csr_index        <= next_index;
      csr_write_data   <= next_data;
      stimulus_done    <= next_done;
   end

   always @(posedge clock) begin : watch_block
      char_word_type want;
      if (reset) begin
         model_radix      = rdf_pkg::RADIX_RESET;
         model_chars_low  = rdf_pkg::CHARS_LOW_RESET;
         model_chars_high = rdf_pkg::CHARS_HIGH_RESET;
         req_taken       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rdf_pkg::CSR_RADIX: begin
                  model_radix = csr_write_data[rdf_pkg::CSR_RADIX_W-1:0];
               end
               rdf_pkg::CSR_CHARS_LOW: begin
                  model_chars_low = csr_write_data;
               end
               rdf_pkg::CSR_CHARS_HIGH: begin
                  model_chars_high = csr_write_data;
               end
               default: ;
            endcase
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            predict_digits(req_value);
         end
         if (rsp_strobe) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("word 0x%02h last %0b with nothing expected",
                                         rsp_character, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.character) begin
                  report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            rsp_character, want.character));
               end
               if (rsp_last !== want.is_last) begin
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_last, want.is_last));
               end
            end
         end
      end
   end

   initial begin : run_test
      logic [rdf_pkg::VALUE_BITS-1:0] number;
      logic [rdf_pkg::CSR_DATA_W-1:0] data;
      int unsigned                    base;
      int unsigned                    sel;
      bit                             no_idle;

      // Reset table, radix ten.
      queue_number(64'd0, $urandom_range(0, 15));
      queue_number(64'd1, $urandom_range(0, 15));
      queue_number(64'd9, $urandom_range(0, 15));
      queue_number(64'd10, $urandom_range(0, 15));
      queue_number(64'd12345678901234567890, $urandom_range(0, 15));
      queue_number('1, $urandom_range(0, 15));

      // Binary gives the longest strings, up to 64 words.
      queue_csr(rdf_pkg::CSR_RADIX, {59'h0, 5'd2});
      queue_number(64'd0, $urandom_range(0, 15));
      queue_number(64'd1, 0);
      queue_number('1, 0);
      queue_number(64'h8000_0000_0000_0000, $urandom_range(0, 15));
      queue_number(64'h5555_5555_5555_5555, $urandom_range(0, 15));

      // Zero bytes and repeated bytes in the table; zero still gives '0'.
      queue_csr(rdf_pkg::CSR_RADIX, {59'h7ff_ffff_ffff_fff, 5'd16});
      queue_csr(rdf_pkg::CSR_CHARS_LOW, 64'h0000_4141_00ff_0000);
      queue_csr(rdf_pkg::CSR_CHARS_HIGH, 64'hffff_ffff_ffff_ffff);
      queue_number('1, $urandom_range(0, 15));
      queue_number(64'h0123_4567_89ab_cdef, $urandom_range(0, 15));
      queue_number(64'd0, $urandom_range(0, 15));

      // Radix below two counts as two; above sixteen counts as sixteen.
      queue_csr(rdf_pkg::CSR_CHARS_LOW, rdf_pkg::CHARS_LOW_RESET);
      queue_csr(rdf_pkg::CSR_CHARS_HIGH, rdf_pkg::CHARS_HIGH_RESET);
      queue_csr(rdf_pkg::CSR_RADIX, 64'd0);
      queue_number(64'd6, $urandom_range(0, 15));
      queue_csr(rdf_pkg::CSR_RADIX, 64'd1);
      queue_number(64'd5, $urandom_range(0, 15));
      queue_csr(rdf_pkg::CSR_RADIX, 64'd31);
      queue_number(64'hfedc_ba98_7654_3210, $urandom_range(0, 15));
      queue_csr(rdf_pkg::CSR_RADIX, 64'd17);
      queue_number(64'd255, $urandom_range(0, 15));

      // A write to the unused index must leave every register alone.
      queue_csr(rdf_pkg::CSR_RADIX, 64'd7);
      queue_csr(CSR_UNUSED, {$urandom, $urandom});
      queue_number(64'd100, $urandom_range(0, 15));
      queue_csr(rdf_pkg::CSR_RADIX, 64'd3);
      queue_number('1, $urandom_range(0, 15));
      queue_drain();

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       base = 2;
            1:       base = 16;
            2:       base = 0;
            3:       base = 31;
            default: base = $urandom_range(0, 31);
         endcase
         data      = {$urandom, $urandom};
         data[4:0] = base[4:0];
         queue_csr(rdf_pkg::CSR_RADIX, data);
         if (phase == 5) begin
            queue_csr(rdf_pkg::CSR_CHARS_LOW, '0);
            queue_csr(rdf_pkg::CSR_CHARS_HIGH, '1);
         end else begin
            queue_csr(rdf_pkg::CSR_CHARS_LOW, {$urandom, $urandom});
            queue_csr(rdf_pkg::CSR_CHARS_HIGH, {$urandom, $urandom});
         end
         no_idle = (phase % 3 == 1);
         for (int i = 0; i < 18; i++) begin
            // Shifting spreads the digit count over its whole range.
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
               number = '0;
            end else if (sel == 1) begin
               number = '1;
            end else begin
               number = {$urandom, $urandom} >> $urandom_range(0, 63);
            end
            queue_number(number, no_idle ? 0 : $urandom_range(0, 15));
            if (phase == 6 && i == 10) begin
               queue_drain();
            end
         end
      end
      queue_csr(rdf_pkg::CSR_RADIX, {59'h0, rdf_pkg::RADIX_RESET});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!stimulus_done) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("radix_digit_formatter_tb OK");
      end else begin
         $display("radix_digit_formatter_tb NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("radix_digit_formatter_tb NOT OK");
      $finish;
   end

endmodule

[radix_digit_formatter.f]
hdl/rdf_pkg.sv
hdl/rdf_csr.sv
hdl/rdf_ctrl.sv
hdl/rdf_dpath.sv
hdl/radix_digit_formatter.sv
tb/radix_digit_formatter_tb.sv
